[src/dld_pkg.sv]
// ----------------------------------------------------------------------------
// dld_pkg
// Shared types and constants for the decimal long division digit writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dld_pkg;

  // number of digits after the point
  localparam int FRACTION_DIGITS = 48;
  // operand width, matches the input fields
  localparam int OPERAND_WIDTH   = 32;
  // width of ten times a remainder below the divisor
  localparam int XW              = OPERAND_WIDTH + 4;
  // character counter covers the integer digit, the point and the fraction
  localparam int POS_W           = $clog2(FRACTION_DIGITS + 2);
  localparam logic [POS_W-1:0] POS_POINT = POS_W'(1);
  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRACTION_DIGITS + 1);

  // task queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_POINT = 8'h2E;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BIG      = 2'd1,
    STATUS_DIV_ZERO = 2'd2
  } status_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

  typedef struct packed {
    logic [31:0] dividend;
    logic [31:0] divisor;
  } in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    status_t    status;
  } out_t;

  // classified work item
  typedef struct packed {
    status_t                  kind;
    logic [OPERAND_WIDTH-1:0] num;
    logic [OPERAND_WIDTH-1:0] den;
  } task_t;

endpackage

[src/decimal_long_division_digits.sv]
// ----------------------------------------------------------------------------
// decimal_long_division_digits
// The first character reaches the output register after passing the input
// register, the task queue and the digit engine's task load. A normal quotient
// then gives one character per cycle while the output slot is free,
// FRACTION_DIGITS + 2 in all; a flagged item gives one character. The digit
// engine takes one item at a time and loads the next only once it is done.
// Reset: synchronous, empties the input register, queue and output slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_long_division_digits
  import dld_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic  push_valid;
  logic  push_ready;
  task_t push_data;
  logic  pop_valid;
  logic  pop_ready;
  task_t pop_data;

  // classify incoming items
  dld_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decouple front from digit engine
  dld_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // write out characters
  dld_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

[src/dld_front.sv]
// ----------------------------------------------------------------------------
// dld_front
// Input stage: registers each item and classifies it as ok, too big or
// divide by zero before handing it to the task queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dld_front
  import dld_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  in_t   in_data,
  output logic  push_valid,
  input  logic  push_ready,
  output task_t push_data
);

  logic             hold_valid;
  in_t              hold;
  logic [XW-1:0]    den_x10;
  logic             is_zero;
  logic             is_big;

  // input register takes a transfer whenever it is empty or draining
  assign in_ready = !hold_valid || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= in_data;
    end
  end

  // quotient of ten or more when dividend reaches ten times the divisor
  assign den_x10 = (XW'(hold.divisor[OPERAND_WIDTH-1:0]) << 3)
                 + (XW'(hold.divisor[OPERAND_WIDTH-1:0]) << 1);
  assign is_zero = (hold.divisor[OPERAND_WIDTH-1:0] == '0);
  assign is_big  = (XW'(hold.dividend[OPERAND_WIDTH-1:0]) >= den_x10);

  always_comb begin
    push_data.num = hold.dividend[OPERAND_WIDTH-1:0];
    push_data.den = hold.divisor[OPERAND_WIDTH-1:0];
    priority if (is_zero) begin
      push_data.kind = STATUS_DIV_ZERO;
    end else if (is_big) begin
      push_data.kind = STATUS_BIG;
    end else begin
      push_data.kind = STATUS_OK;
    end
  end

  assign push_valid = hold_valid;

endmodule

[src/dld_queue.sv]
// ----------------------------------------------------------------------------
// dld_queue
// Short task queue that decouples the input stage from the digit engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dld_queue
  import dld_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  task_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output task_t pop_data
);

  task_t             entry [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

[src/dld_back.sv]
// ----------------------------------------------------------------------------
// dld_back
// Digit engine: takes one task at a time and writes its characters, one
// decimal digit recurrence per cycle while the output slot is free, into a registered output slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dld_back
  import dld_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  pop_valid,
  output logic  pop_ready,
  input  task_t pop_data,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  back_state_t       state;
  back_state_t       state_next;
  status_t           kind;
  logic [XW-1:0]     x;
  logic [XW-1:0]     mult [1:9];
  logic [POS_W-1:0]  pos;
  logic              slot_free;
  logic              step;
  logic              fin;
  logic [XW:0]       diff [1:9];
  logic [3:0]        digit;
  logic [XW-1:0]     rem;
  logic [XW-1:0]     x_next;
  out_t              res_next;

  assign slot_free = !out_valid || out_ready;
  assign fin       = (kind != STATUS_OK) || (pos == LAST_POS);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshakes
  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    step       = 1'b0;
    unique case (state)
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_next = B_RUN;
        end
      end
      B_RUN: begin
        if (slot_free) begin
          step = 1'b1;
          if (fin) begin
            state_next = B_IDLE;
          end
        end
      end
    endcase
  end

  // digit select against the nine divisor multiples
  always_comb begin
    digit = 4'd0;
    rem   = x;
    for (int k = 1; k <= 9; k++) begin
      diff[k] = {1'b0, x} - {1'b0, mult[k]};
      if (!diff[k][XW]) begin
        digit = 4'(k);
        rem   = diff[k][XW-1:0];
      end
    end
    x_next = (rem << 3) + (rem << 1);
  end

  // character for the current position
  always_comb begin
    res_next.status = kind;
    res_next.last   = fin;
    if (kind != STATUS_OK) begin
      res_next.character = 8'd0;
    end else if (pos == POS_POINT) begin
      res_next.character = CHAR_POINT;
    end else begin
      res_next.character = CHAR_ZERO + {4'd0, digit};
    end
  end

  // output slot valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // task load and recurrence registers
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      kind <= pop_data.kind;
      x    <= XW'(pop_data.num);
      pos  <= '0;
      for (int k = 1; k <= 9; k++) begin
        mult[k] <= XW'(pop_data.den) * XW'(k);
      end
    end else if (step) begin
      pos <= pos + 1'b1;
      if (pos != POS_POINT) begin
        x <= x_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= res_next;
    end
  end

  // flagged items always come as a single final character
  a_flag_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != STATUS_OK) |-> out_data.last)
    else $error("flagged result without last");

  // ok characters are a digit or the point
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == STATUS_OK) |->
      (out_data.character == CHAR_POINT) ||
      ((out_data.character >= CHAR_ZERO) && (out_data.character <= CHAR_ZERO + 8'd9)))
    else $error("bad character");

  // partial dividend stays below ten times the divisor
  a_x_bound: assert property (@(posedge clk) disable iff (rst)
    (state == B_RUN) && (kind == STATUS_OK) |-> (x < (mult[9] + mult[1])))
    else $error("partial dividend out of range");

  // the point is never the final character
  a_point_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.character == CHAR_POINT) |-> !out_data.last)
    else $error("point marked last");

endmodule
